FILE: src/oled_i2c_byte_writer_assert.svh
// Assertion macros used by the checker file of the I2C byte writer.
// No dependencies; include by bare file name.
`ifndef OLED_I2C_BYTE_WRITER_ASSERT_SVH
`define OLED_I2C_BYTE_WRITER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define OIB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define OIB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/oib_pkg.sv
// Shared types and constants of the I2C byte writer.
// No dependencies.
package oib_pkg;

   localparam int unsigned STEP_WIDTH = 7;
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   localparam logic [STEP_WIDTH-1:0] START_STEPS = 7'd4;
   localparam logic [STEP_WIDTH-1:0] BYTE_STEPS = 7'd28;
   localparam logic [STEP_WIDTH-1:0] SEQ_LEN = 7'd94;
   localparam logic [STEP_WIDTH-1:0] LAST_STEP = 7'd93;

   localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'h78;
   localparam logic [7:0] DATA_CONTROL_RESET = 8'h40;
   localparam logic [7:0] COMMAND_CONTROL_RESET = 8'h00;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SLAVE_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DATA_CONTROL = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COMMAND_CONTROL = 2'd2;

   typedef struct packed {
      logic [7:0] slave_address;
      logic [7:0] data_control;
      logic [7:0] command_control;
   } cfg_type;

   typedef struct packed {
      logic scl;
      logic sda;
   } line_type;

   typedef struct packed {
      logic scl_level;
      logic sda_level;
      logic busy_res;
      logic accepted;
      logic finished;
   } rsp_type;

endpackage

FILE: src/oib_step_decode.sv
// Pin operation decode: maps a sequence step to the next SCL/SDA levels.
// Depends on oib_pkg.
module oib_step_decode (
   input  logic [oib_pkg::STEP_WIDTH-1:0] step,
   input  oib_pkg::cfg_type               cfg,
   input  logic [7:0]                     held_payload,
   input  logic                           held_data_flag,
   input  oib_pkg::line_type              lines_cur,
   output oib_pkg::line_type              lines_next
);

   logic [oib_pkg::STEP_WIDTH-1:0] offset;
   logic [4:0]                     r;
   logic [7:0]                     value;
   logic                           in_byte;

   always_comb begin
      in_byte = 1'b1;
      value = cfg.slave_address;
      offset = step - oib_pkg::START_STEPS;
      if (step < oib_pkg::START_STEPS) begin
         in_byte = 1'b0;
      end else if (step < oib_pkg::START_STEPS + oib_pkg::BYTE_STEPS) begin
         offset = step - oib_pkg::START_STEPS;
      end else if (step < oib_pkg::START_STEPS + 7'(2 * oib_pkg::BYTE_STEPS)) begin
         offset = step - oib_pkg::START_STEPS - oib_pkg::BYTE_STEPS;
         value = held_data_flag ? cfg.data_control : cfg.command_control;
      end else if (step < oib_pkg::START_STEPS + 7'(3 * oib_pkg::BYTE_STEPS)) begin
         offset = step - oib_pkg::START_STEPS - 7'(2 * oib_pkg::BYTE_STEPS);
         value = held_payload;
      end else begin
         in_byte = 1'b0;
      end
      r = offset[4:0];
   end

   always_comb begin
      lines_next = lines_cur;
      if (in_byte) begin
         if (r < 5'd24) begin
            for (int b = 0; b < 8; b++) begin
               if (r == 5'(3 * b)) begin
                  lines_next.scl = 1'b0;
               end else if (r == 5'(3 * b + 1)) begin
                  lines_next.sda = value[7 - b];
               end else if (r == 5'(3 * b + 2)) begin
                  lines_next.scl = 1'b1;
               end
            end
         end else begin
            case (r)
               5'd24:   lines_next.scl = 1'b0;
               5'd25:   lines_next.sda = 1'b1;
               5'd26:   lines_next.scl = 1'b1;
               default: lines_next.scl = 1'b0;
            endcase
         end
      end else begin
         case (step)
            7'd0:    lines_next.scl = 1'b1;
            7'd1:    lines_next.sda = 1'b1;
            7'd2:    lines_next.sda = 1'b0;
            7'd3:    lines_next.scl = 1'b0;
            7'd88:   lines_next.scl = 1'b1;
            7'd89:   lines_next.scl = 1'b0;
            7'd90:   lines_next.scl = 1'b0;
            7'd91:   lines_next.sda = 1'b0;
            7'd92:   lines_next.scl = 1'b1;
            default: lines_next.sda = 1'b1;
         endcase
      end
   end

endmodule

FILE: src/oled_i2c_byte_writer.sv
// Top level of the write-only I2C byte writer for a display controller.
// Depends on oib_pkg and oib_step_decode.
//
// Usage:
//   req channel: req_command 1 submits req_payload_byte with req_is_data;
//   req_command 0 is a tick that performs the next pin step of the 94-step
//   frame (start, address, control, payload, extra ack clock, stop).
//   A submit while a frame is in progress is refused (rsp_accepted 0).
//   rsp channel: one beat per request beat, carrying the SCL/SDA levels
//   after the step plus busy, accepted and finished flags.
//   csr channel: index 0 slave address byte, 1 data control byte,
//   2 command control byte; always ready, other indexes ignored.
// Response: valid in the cycle after its request beat, or later from skid.
// Throughput: one request beat per cycle while req_ready is high; the step
//   counter and its decode finish the pin operation within that cycle.
// Stall: a two-entry output buffer holds responses; req_ready drops only
//   when both entries are full, and rises once rsp_ready drains one.
// Reset: lines read high, idle, configuration at its defaults, buffer empty.
module oled_i2c_byte_writer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_command,
   input  logic [7:0]                          req_payload_byte,
   input  logic                                req_is_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_scl_level,
   output logic                                rsp_sda_level,
   output logic                                rsp_busy_res,
   output logic                                rsp_accepted,
   output logic                                rsp_finished,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [oib_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]                          csr_wdata
);

   oib_pkg::cfg_type               cfg_ff;
   logic [oib_pkg::STEP_WIDTH-1:0] step_ff, step_in, step_sat;
   logic [7:0]                     payload_ff, payload_in;
   logic                           flag_ff, flag_in;
   logic                           active_ff, active_in;
   oib_pkg::line_type              lines_ff, lines_in, lines_next;
   oib_pkg::rsp_type               result;
   oib_pkg::rsp_type               out_ff, out_in, skid_ff, skid_in;
   logic                           out_valid_ff, out_valid_in;
   logic                           skid_valid_ff, skid_valid_in;
   logic                           take, pop;

   assign csr_ready = 1'b1;
   assign req_ready = !skid_valid_ff;
   assign take = req_valid && req_ready;
   assign pop = out_valid_ff && rsp_ready;
   assign step_sat = (step_ff >= oib_pkg::SEQ_LEN) ? oib_pkg::LAST_STEP : step_ff;

   oib_step_decode u_decode (
      .step           (step_sat),
      .cfg            (cfg_ff),
      .held_payload   (payload_ff),
      .held_data_flag (flag_ff),
      .lines_cur      (lines_ff),
      .lines_next     (lines_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slave_address <= oib_pkg::SLAVE_ADDRESS_RESET;
         cfg_ff.data_control <= oib_pkg::DATA_CONTROL_RESET;
         cfg_ff.command_control <= oib_pkg::COMMAND_CONTROL_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            oib_pkg::CSR_SLAVE_ADDRESS:   cfg_ff.slave_address <= csr_wdata;
            oib_pkg::CSR_DATA_CONTROL:    cfg_ff.data_control <= csr_wdata;
            oib_pkg::CSR_COMMAND_CONTROL: cfg_ff.command_control <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequence state update and response for the accepted beat
   always_comb begin
      step_in = step_ff;
      payload_in = payload_ff;
      flag_in = flag_ff;
      active_in = active_ff;
      lines_in = lines_ff;
      result.accepted = 1'b0;
      result.finished = 1'b0;
      if (take) begin
         if (req_command) begin
            if (!active_ff) begin
               payload_in = req_payload_byte;
               flag_in = req_is_data;
               step_in = '0;
               active_in = 1'b1;
               result.accepted = 1'b1;
            end
         end else if (active_ff) begin
            lines_in = lines_next;
            if (step_sat == oib_pkg::LAST_STEP) begin
               active_in = 1'b0;
               step_in = '0;
               result.finished = 1'b1;
            end else begin
               step_in = step_sat + 7'd1;
            end
         end
      end
      result.scl_level = lines_in.scl;
      result.sda_level = lines_in.sda;
      result.busy_res = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         payload_ff <= '0;
         flag_ff <= 1'b0;
         active_ff <= 1'b0;
         lines_ff <= '{scl: 1'b1, sda: 1'b1};
      end else begin
         step_ff <= step_in;
         payload_ff <= payload_in;
         flag_ff <= flag_in;
         active_ff <= active_in;
         lines_ff <= lines_in;
      end
   end

   // two-entry response buffer: output register plus skid
   always_comb begin
      out_in = out_ff;
      out_valid_in = out_valid_ff;
      skid_in = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_in = result;
            out_valid_in = take;
         end
      end else if (!out_valid_ff) begin
         out_in = result;
         out_valid_in = take;
      end else if (take) begin
         skid_in = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_scl_level = out_ff.scl_level;
   assign rsp_sda_level = out_ff.sda_level;
   assign rsp_busy_res = out_ff.busy_res;
   assign rsp_accepted = out_ff.accepted;
   assign rsp_finished = out_ff.finished;

endmodule

FILE: src/oib_checker.sv
// Port-level checks of the I2C byte writer, bound to the top level.
// Depends on oled_i2c_byte_writer_assert.svh.
`include "oled_i2c_byte_writer_assert.svh"

module oib_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_scl_level,
   input logic rsp_sda_level,
   input logic rsp_busy_res,
   input logic rsp_accepted,
   input logic rsp_finished
);

   `OIB_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid,
      "response beat dropped while stalled")
   `OIB_ASSERT_IMPLY(a_acc_busy, clock, reset, rsp_valid && rsp_accepted,
      rsp_busy_res && !rsp_finished, "accepted submit without busy")
   `OIB_ASSERT_IMPLY(a_fin_idle, clock, reset, rsp_valid && rsp_finished,
      !rsp_busy_res && rsp_scl_level && rsp_sda_level, "stop did not release lines")
   `OIB_ASSERT_NEXT(a_beat_resp, clock, reset, req_valid && req_ready, rsp_valid,
      "request beat without response")

endmodule

bind oled_i2c_byte_writer oib_checker u_oib_checker (.*);
